/* hdl/edtrs_pkg.sv */
// shared types, widths and constants of the per-source rate shaper
package edtrs_pkg;

  // default table depth
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  // field widths
  localparam int unsigned SRC_W      = 32;
  localparam int unsigned RATE_W     = 40;
  localparam int unsigned TS_W       = 64;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned PROTO_W    = 8;
  localparam int unsigned TOS_W      = 8;
  localparam int unsigned DSCP_W     = 6;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // length times nanoseconds per second
  localparam int unsigned NS_W = 30;
  localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1_000_000_000;
  localparam int unsigned PROD_W = LEN_W + NS_W;

  // protocol constants
  localparam logic [PROTO_W-1:0] PROTO_UDP        = 8'd17;
  localparam logic [PORT_W-1:0]  TUNNEL_PORT_RST  = 16'd6081;
  localparam int unsigned        DSCP_SHIFT       = 2;

  typedef enum logic {
    REQ_PACKET  = 1'b0,
    REQ_INSTALL = 1'b1
  } req_e;

  typedef enum logic {
    VERDICT_PASS = 1'b0,
    VERDICT_DROP = 1'b1
  } verdict_e;

  typedef enum logic [2:0] {
    STAT_NOT_SHAPED = 3'd0,
    STAT_NO_ENTRY   = 3'd1,
    STAT_SHAPED     = 3'd2,
    STAT_INSTALLED  = 3'd3,
    STAT_TABLE_FULL = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TUNNEL_PORT = 8'd0,
    CFG_DSCP_HIGH   = 8'd1,
    CFG_DSCP_MEDIUM = 8'd2,
    CFG_DSCP_LOW    = 8'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASSIFY,
    S_SCAN,
    S_INSTALL,
    S_MUL,
    S_DIV,
    S_CALC,
    S_DECIDE,
    S_FINISH
  } state_e;

  // one source table row
  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [RATE_W-1:0] rate;
    logic [TS_W-1:0]   horizon;
    logic [TS_W-1:0]   last;
  } entry_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/edtrs_divider.sv */
// radix-2 restoring divider, one quotient bit per cycle
module edtrs_divider import edtrs_pkg::*; #(
  parameter int unsigned N_W = PROD_W,
  parameter int unsigned D_W = RATE_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic [N_W-1:0] quotient_o,
  output div_stat_t      stat_o
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [D_W-1:0]   rem_q, rem_d;
  logic [N_W-1:0]   quo_q, quo_d;
  logic [D_W-1:0]   dvs_q, dvs_d;

  logic [D_W:0]     shifted;
  logic [D_W:0]     trial;
  logic             ge;

  // one shift and trial subtract
  assign shifted = {rem_q, quo_q[N_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(N_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? trial[D_W-1:0] : shifted[D_W-1:0];
      quo_d = {quo_q[N_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* hdl/edt_per_source_rate_shaper.sv */
// top level of the earliest-departure-time per-source rate shaper
//
// Request beats enter on in_valid_i/in_ready_o: a packet descriptor
// (req_type 0) or an install of a source table entry (req_type 1). Each
// request gives exactly one result beat on out_valid_o/out_ready_i.
// Configuration writes come on cfg_valid_i/cfg_ready_o and are always taken.
// One request is worked on at a time; in_ready_o is high only when idle.
// A packet passes through a classify state, a table scan of one entry
// per cycle, a multiply state, the radix-2 divider (one quotient bit per
// cycle for the 46-bit dividend), the add/compare states and a finish
// state that loads the output register. Zero-rate entries skip the divider.
// An install passes through the scan, an install state and the finish
// state; a frame that is not shaped goes from classify to finish.
// The result sits in an output register; a new request is taken while it
// waits, and a finished result holds in the sequencer until the slot frees.
// Reset empties the table (fill count zero) and restores register defaults.
module edt_per_source_rate_shaper import edtrs_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [SRC_W-1:0]      src_addr_i,
  input  logic                  frame_long_enough_i,
  input  logic [PROTO_W-1:0]    ip_protocol_i,
  input  logic [PORT_W-1:0]     udp_dst_port_i,
  input  logic [TOS_W-1:0]      ip_tos_i,
  input  logic [LEN_W-1:0]      wire_length_i,
  input  logic [TS_W-1:0]       pkt_timestamp_i,
  input  logic [TS_W-1:0]       now_ns_i,
  input  logic [RATE_W-1:0]     entry_bandwidth_i,
  input  logic [TS_W-1:0]       entry_horizon_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  verdict_o,
  output logic [TS_W-1:0]       new_timestamp_o,
  output logic                  timestamp_changed_o,
  output logic [2:0]            status_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  state_e state_q, state_d;

  // configuration registers
  logic [PORT_W-1:0] tunnel_port_q;
  logic [DSCP_W-1:0] dscp_high_q, dscp_medium_q, dscp_low_q;

  // captured request
  req_e              req_q;
  logic [SRC_W-1:0]  src_q;
  logic              long_q;
  logic [PROTO_W-1:0] proto_q;
  logic [PORT_W-1:0] dport_q;
  logic [TOS_W-1:0]  tos_q;
  logic [LEN_W-1:0]  wlen_q;
  logic [TS_W-1:0]   ts_q, now_q;
  logic [RATE_W-1:0] bw_q;
  logic [TS_W-1:0]   hor_q;

  // table
  entry_t            mem [TABLE_ENTRIES];
  entry_t            rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [CNT_W-1:0]  fill_q, fill_d;

  // scan state
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pidx_q, pidx_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  entry_t            ent_q, ent_d;
  logic              hit, miss, shaped;
  logic [DSCP_W-1:0] dscp;

  // arithmetic
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quotient;
  div_stat_t         div_stat;
  logic              div_start;
  logic [TS_W-1:0]   delay_q, delay_d;
  logic [TS_W-1:0]   t_q, t_d;
  logic [TS_W-1:0]   t_next_q, t_next_d;
  logic [TS_W-1:0]   ahead;
  logic              no_wait, beyond;

  // pending result
  verdict_e          res_verdict_q, res_verdict_d;
  logic [TS_W-1:0]   res_ts_q, res_ts_d;
  logic              res_chg_q, res_chg_d;
  status_e           res_status_q, res_status_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  verdict_e          out_verdict_q;
  logic [TS_W-1:0]   out_ts_q;
  logic              out_chg_q;
  status_e           out_status_q;

  logic              in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tunnel_port_q <= TUNNEL_PORT_RST;
      dscp_high_q   <= '0;
      dscp_medium_q <= '0;
      dscp_low_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TUNNEL_PORT: tunnel_port_q <= cfg_data_i;
        CFG_DSCP_HIGH:   dscp_high_q   <= cfg_data_i[DSCP_W-1:0];
        CFG_DSCP_MEDIUM: dscp_medium_q <= cfg_data_i[DSCP_W-1:0];
        CFG_DSCP_LOW:    dscp_low_q    <= cfg_data_i[DSCP_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q   <= req_e'(req_type_i);
      src_q   <= src_addr_i;
      long_q  <= frame_long_enough_i;
      proto_q <= ip_protocol_i;
      dport_q <= udp_dst_port_i;
      tos_q   <= ip_tos_i;
      wlen_q  <= wire_length_i;
      ts_q    <= pkt_timestamp_i;
      now_q   <= now_ns_i;
      bw_q    <= entry_bandwidth_i;
      hor_q   <= entry_horizon_i;
    end
  end

  // shaping filter
  assign dscp   = tos_q[TOS_W-1:DSCP_SHIFT];
  assign shaped = long_q && (proto_q == PROTO_UDP) && (dport_q == tunnel_port_q) &&
                  ((dscp == dscp_high_q) || (dscp == dscp_medium_q) ||
                   (dscp == dscp_low_q));

  // scan compare on the previous cycle's read
  assign hit  = pend_q && (rd_q.source == src_q);
  assign miss = !hit && (scan_q == fill_q);

  // delay dividend and shared divider
  assign prod = PROD_W'(wlen_q) * PROD_W'(NS_PER_SEC);

  edtrs_divider #(
    .N_W (PROD_W),
    .D_W (RATE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (ent_q.rate),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // departure decision
  assign no_wait = t_next_q <= t_q;
  assign ahead   = t_next_q - now_q;
  assign beyond  = ahead >= ent_q.horizon;

  // table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_addr = scan_q[IDX_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        if (req_q == REQ_INSTALL || shaped) state_d = S_SCAN;
        else state_d = S_FINISH;
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (req_q == REQ_INSTALL) ? S_INSTALL : S_MUL;
        end else if (miss) begin
          state_d = (req_q == REQ_INSTALL) ? S_INSTALL : S_FINISH;
        end
      end
      S_INSTALL: state_d = S_FINISH;
      S_MUL: begin
        state_d = (ent_q.rate == '0) ? S_CALC : S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) state_d = S_CALC;
      end
      S_CALC:   state_d = S_DECIDE;
      S_DECIDE: state_d = S_FINISH;
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    fill_d        = fill_q;
    scan_d        = scan_q;
    pend_d        = pend_q;
    pidx_d        = pidx_q;
    found_d       = found_q;
    hit_idx_d     = hit_idx_q;
    ent_d         = ent_q;
    delay_d       = delay_q;
    t_d           = t_q;
    t_next_d      = t_next_q;
    res_verdict_d = res_verdict_q;
    res_ts_d      = res_ts_q;
    res_chg_d     = res_chg_q;
    res_status_d  = res_status_q;
    wr_en         = 1'b0;
    wr_addr       = hit_idx_q;
    wr_data       = ent_q;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        scan_d  = '0;
        pend_d  = 1'b0;
        found_d = 1'b0;
      end
      S_CLASSIFY: begin
        res_verdict_d = VERDICT_PASS;
        res_ts_d      = ts_q;
        res_chg_d     = 1'b0;
        res_status_d  = STAT_NOT_SHAPED;
      end
      S_SCAN: begin
        if (hit) begin
          found_d   = 1'b1;
          hit_idx_d = pidx_q;
          ent_d     = rd_q;
        end else if (miss) begin
          res_status_d = STAT_NO_ENTRY;
        end else begin
          pend_d = 1'b1;
          pidx_d = scan_q[IDX_W-1:0];
          scan_d = scan_q + 1'b1;
        end
      end
      S_INSTALL: begin
        wr_data.source  = src_q;
        wr_data.rate    = bw_q;
        wr_data.horizon = hor_q;
        wr_data.last    = '0;
        res_verdict_d   = VERDICT_PASS;
        res_ts_d        = '0;
        res_chg_d       = 1'b0;
        res_status_d    = STAT_INSTALLED;
        if (found_q) begin
          wr_en = 1'b1;
        end else if (fill_q != CNT_W'(TABLE_ENTRIES)) begin
          wr_en   = 1'b1;
          wr_addr = fill_q[IDX_W-1:0];
          fill_d  = fill_q + 1'b1;
        end else begin
          res_status_d = STAT_TABLE_FULL;
        end
      end
      S_MUL: begin
        delay_d = '0;
        if (ent_q.rate != '0) div_start = 1'b1;
      end
      S_DIV: begin
        if (div_stat.done) delay_d = TS_W'(quotient);
      end
      S_CALC: begin
        t_d      = (ts_q < now_q) ? now_q : ts_q;
        t_next_d = ent_q.last + delay_q;
      end
      S_DECIDE: begin
        res_status_d  = STAT_SHAPED;
        res_verdict_d = VERDICT_PASS;
        res_ts_d      = ts_q;
        res_chg_d     = 1'b0;
        if (no_wait) begin
          wr_en        = 1'b1;
          wr_data.last = t_q;
        end else if (beyond) begin
          res_verdict_d = VERDICT_DROP;
        end else begin
          wr_en        = 1'b1;
          wr_data.last = t_next_q;
          res_ts_d     = t_next_q;
          res_chg_d    = 1'b1;
        end
      end
      S_FINISH: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  // result slot handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    pidx_q        <= pidx_d;
    hit_idx_q     <= hit_idx_d;
    ent_q         <= ent_d;
    delay_q       <= delay_d;
    t_q           <= t_d;
    t_next_q      <= t_next_d;
    res_verdict_q <= res_verdict_d;
    res_ts_q      <= res_ts_d;
    res_chg_q     <= res_chg_d;
    res_status_q  <= res_status_d;
  end

  // output register load
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_verdict_q <= res_verdict_q;
      out_ts_q      <= res_ts_q;
      out_chg_q     <= res_chg_q;
      out_status_q  <= res_status_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign verdict_o           = out_verdict_q;
  assign new_timestamp_o     = out_ts_q;
  assign timestamp_changed_o = out_chg_q;
  assign status_o            = out_status_q;

endmodule
